[rtl/core/tid_pkg.sv]
// ----------------------------------------------------------------------------
// tid_pkg
// Types, constants and helpers shared by the integrated-DOS pipeline.
// ----------------------------------------------------------------------------
package tid_pkg;

    localparam int E_W       = 32;  // energy field width
    localparam int Q_W       = 33;  // Q1.32 ratio width
    localparam int W_W       = 32;  // weight / share width
    localparam int N_LANES   = 6;   // parallel divider lanes
    localparam int DIV_STEPS = 32;  // quotient bits per ratio

    localparam logic [Q_W-1:0] ONE_Q = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic [E_W-1:0] t_diff;
    typedef logic [Q_W-1:0] t_q;

    typedef struct packed {
        logic signed [E_W-1:0] query_energy;
        logic signed [E_W-1:0] vertex_energy_a;
        logic signed [E_W-1:0] vertex_energy_b;
        logic signed [E_W-1:0] vertex_energy_c;
        logic signed [E_W-1:0] vertex_energy_d;
    } t_in_item;

    typedef struct packed {
        logic [W_W-1:0] state_count_share;
        logic           order_error;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_ZERO,
        REG_LOW,
        REG_MID,
        REG_HIGH,
        REG_ONE,
        REG_ERR
    } t_region;

    typedef struct packed {
        logic    valid;
        t_region region;
    } t_ctl;

    // Truncating product of two Q1.32 values in [0,1].
    function automatic t_q mul_q(t_q x, t_q y);
        logic [2*(Q_W-1)-1:0] p;
        p = x[Q_W-2:0] * y[Q_W-2:0];
        if (x >= ONE_Q)
            return (y > ONE_Q) ? ONE_Q : y;
        else if (y >= ONE_Q)
            return x;
        else
            return {1'b0, p[2*(Q_W-1)-1:Q_W-1]};
    endfunction

endpackage

[rtl/core/tetrahedron_integrated_dos.sv]
// ----------------------------------------------------------------------------
// tetrahedron_integrated_dos
// Tetrahedron-method integrated density of states share of one tetrahedron.
// ----------------------------------------------------------------------------
// Each item carries a query energy and four vertex energies (signed Q16.16,
// expected ascending). The block returns floor(frac * weight) in Q0.32, where
// frac is the piecewise cubic fraction of the tetrahedron's states at or
// below the query energy, clamped to [0,1]; non-ascending vertices set
// order_error and return zero. Throughput is one item per clock while the
// output is not stalled. The pipeline runs through region decode, six parallel
// one-bit-per-stage dividers that form the Q1.32 ratios, two multiply
// stages, one fraction stage and the weight multiply into the output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stall holds every item in place.
// The weight register resets to 0xFFFFFFFF and should be written only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tetrahedron_integrated_dos (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tid_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tid_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic [tid_pkg::W_W-1:0]    i_cfg_data
);
    import tid_pkg::*;

    logic           en;
    logic [W_W-1:0] r_weight;

    t_diff num   [N_LANES];
    t_diff den   [N_LANES];
    t_q    ratio [N_LANES];
    t_ctl  front_ctl;
    t_ctl  r_ctl_dly [DIV_STEPS];

    // global advance: output register empty or draining
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '1;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_data;
        end
    end

    tid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_num   (num),
        .o_den   (den),
        .o_ctl   (front_ctl)
    );

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        tid_div_lane u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_num   (num[g]),
            .i_den   (den[g]),
            .o_ratio (ratio[g])
        );
    end

    // control rides alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_ctl_dly[k] <= '{valid: 1'b0, region: REG_ZERO};
        end else if (en) begin
            r_ctl_dly[0] <= front_ctl;
            for (int k = 1; k < DIV_STEPS; k++) r_ctl_dly[k] <= r_ctl_dly[k-1];
        end
    end

    tid_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (r_ctl_dly[DIV_STEPS-1]),
        .i_ratio  (ratio),
        .i_weight (r_weight),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item)
    );

endmodule

[rtl/core/tid_front.sv]
// ----------------------------------------------------------------------------
// tid_front
// Order check, region decode and divider operand selection.
// ----------------------------------------------------------------------------
module tid_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tid_pkg::t_in_item  i_item,
    output tid_pkg::t_diff     o_num [tid_pkg::N_LANES],
    output tid_pkg::t_diff     o_den [tid_pkg::N_LANES],
    output tid_pkg::t_ctl      o_ctl
);
    import tid_pkg::*;

    t_diff   r_num [N_LANES];
    t_diff   r_den [N_LANES];
    t_ctl    r_ctl;
    t_diff   n_num [N_LANES];
    t_diff   n_den [N_LANES];
    t_region n_region;

    logic signed [E_W-1:0] e, e1, e2, e3, e4;
    t_diff a, b, c, x, y, z, ca, ba, cb;

    always_comb begin
        e  = i_item.query_energy;
        e1 = i_item.vertex_energy_a;
        e2 = i_item.vertex_energy_b;
        e3 = i_item.vertex_energy_c;
        e4 = i_item.vertex_energy_d;
        // differences are non-negative and fit E_W bits when ordered
        a  = t_diff'(e2 - e1);
        b  = t_diff'(e3 - e1);
        c  = t_diff'(e4 - e1);
        x  = t_diff'(e - e1);
        y  = t_diff'(e - e2);
        z  = t_diff'(e4 - e);
        ca = t_diff'(e4 - e2);
        ba = t_diff'(e3 - e2);
        cb = t_diff'(e4 - e3);

        if (!(e1 <= e2 && e2 <= e3 && e3 <= e4)) n_region = REG_ERR;
        else if (e <= e1)                         n_region = REG_ZERO;
        else if (e <= e2)                         n_region = REG_LOW;
        else if (e <= e3)                         n_region = REG_MID;
        else if (e <= e4)                         n_region = REG_HIGH;
        else                                      n_region = REG_ONE;

        for (int i = 0; i < N_LANES; i++) begin
            n_num[i] = '0;
            n_den[i] = '0;
        end
        unique case (n_region)
            REG_LOW: begin
                n_num[0] = x; n_den[0] = a;
                n_num[1] = x; n_den[1] = b;
                n_num[2] = x; n_den[2] = c;
            end
            REG_MID: begin
                n_num[0] = a; n_den[0] = b;
                n_num[1] = a; n_den[1] = c;
                n_num[2] = y; n_den[2] = b;
                n_num[3] = y; n_den[3] = c;
                n_num[4] = y; n_den[4] = ca;
                n_num[5] = y; n_den[5] = ba;
            end
            REG_HIGH: begin
                n_num[0] = z; n_den[0] = c;
                n_num[1] = z; n_den[1] = ca;
                n_num[2] = z; n_den[2] = cb;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl.region <= n_region;
            r_num        <= n_num;
            r_den        <= n_den;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_ctl = r_ctl;

endmodule

[rtl/core/tid_div_lane.sv]
// ----------------------------------------------------------------------------
// tid_div_lane
// Pipelined restoring divider, one quotient bit per stage, Q1.32 result.
// ----------------------------------------------------------------------------
module tid_div_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  tid_pkg::t_diff  i_num,
    input  tid_pkg::t_diff  i_den,
    output tid_pkg::t_q     o_ratio
);
    import tid_pkg::*;

    t_diff                r_rem [DIV_STEPS];
    t_diff                r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS];
    logic                 r_sat [DIV_STEPS];

    t_diff                n_rem [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quo [DIV_STEPS];

    always_comb begin
        logic [E_W:0]         sh;
        t_diff                prem;
        t_diff                pden;
        logic [DIV_STEPS-1:0] pquo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            prem = (k == 0) ? i_num : r_rem[(k == 0) ? 0 : k-1];
            pden = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
            pquo = (k == 0) ? '0    : r_quo[(k == 0) ? 0 : k-1];
            sh   = {prem, 1'b0};
            if (sh >= {1'b0, pden}) begin
                n_rem[k] = t_diff'(sh - {1'b0, pden});
                n_quo[k] = {pquo[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[E_W-1:0];
                n_quo[k] = {pquo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
                // zero divisor or num >= den saturates at one
                r_sat[k] <= (k == 0) ? (i_den == '0 || i_num >= i_den)
                                     : r_sat[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_ratio = r_sat[DIV_STEPS-1] ? ONE_Q : {1'b0, r_quo[DIV_STEPS-1]};

endmodule

[rtl/core/tid_poly.sv]
// ----------------------------------------------------------------------------
// tid_poly
// Ratio products, piecewise cubic select/clamp, weight scaling, output reg.
// ----------------------------------------------------------------------------
module tid_poly (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  tid_pkg::t_ctl               i_ctl,
    input  tid_pkg::t_q                 i_ratio [tid_pkg::N_LANES],
    input  logic [tid_pkg::W_W-1:0]     i_weight,
    output logic                        o_valid,
    output tid_pkg::t_out_item          o_item
);
    import tid_pkg::*;

    // stage 1: pair products
    t_ctl r1_ctl;
    t_q   r1_q0, r1_q1, r1_q2, r1_q3, r1_r2, r1_r4;
    // stage 2: triple products
    t_ctl r2_ctl;
    t_q   r2_u0, r2_u1, r2_u2, r2_q0, r2_q1, r2_q2;
    // stage 3: fraction
    t_ctl r3_ctl;
    t_q   r3_frac;
    // output
    logic      r_valid;
    t_out_item r_item;

    logic [Q_W+2:0]       plus;
    logic [Q_W+2:0]       minus;
    t_q                   n_frac;
    logic [Q_W+W_W-1:0]   prod;

    always_comb begin
        plus  = {3'b0, r2_q0} + 3 * {3'b0, r2_q1} + 3 * {3'b0, r2_q2};
        minus = {3'b0, r2_u1} + {3'b0, r2_u2};
        unique case (r2_ctl.region)
            REG_LOW:  n_frac = r2_u0;
            REG_MID: begin
                if (plus <= minus)
                    n_frac = '0;
                else if ((plus - minus) > {3'b0, ONE_Q})
                    n_frac = ONE_Q;
                else
                    n_frac = t_q'(plus - minus);
            end
            REG_HIGH: n_frac = ONE_Q - r2_u0;
            REG_ONE:  n_frac = ONE_Q;
            default:  n_frac = '0;
        endcase
        prod = r3_frac * i_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else if (i_en) begin
            r1_ctl.valid <= i_ctl.valid;
            r2_ctl.valid <= r1_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
            r_valid      <= r3_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctl.region <= i_ctl.region;
            r1_q0 <= mul_q(i_ratio[0], i_ratio[1]);
            r1_q1 <= mul_q(i_ratio[0], i_ratio[3]);
            r1_q2 <= mul_q(i_ratio[2], i_ratio[3]);
            r1_q3 <= mul_q(i_ratio[2], i_ratio[5]);
            r1_r2 <= i_ratio[2];
            r1_r4 <= i_ratio[4];

            r2_ctl.region <= r1_ctl.region;
            r2_u0 <= mul_q(r1_q0, r1_r2);
            r2_u1 <= mul_q(r1_q2, r1_r4);
            r2_u2 <= mul_q(r1_q3, r1_r4);
            r2_q0 <= r1_q0;
            r2_q1 <= r1_q1;
            r2_q2 <= r1_q2;

            r3_ctl.region <= r2_ctl.region;
            r3_frac       <= n_frac;

            r_item.state_count_share <= prod[2*W_W-1:W_W];
            r_item.order_error       <= (r3_ctl.region == REG_ERR);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
